### sv/cfd_pkg.sv
// Package for the chunked frame deframer: word types, phase codes, markers
// and constants. No dependencies.
`default_nettype none

package cfd_pkg;

  localparam int unsigned BUFFER_BYTES = 131072;

  localparam int unsigned WI_BITS = 25;
  localparam int unsigned IC_BITS = 17;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  localparam logic REG_CHUNK_BYTES   = 1'b0;
  localparam logic REG_TIMEOUT_TICKS = 1'b1;

  localparam logic [15:0] CHUNK_BYTES_RESET   = 16'd512;
  localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd1000;

  localparam logic [31:0] MARK_START       = 32'hFFAAFFAA;
  localparam logic [31:0] MARK_CHUNK_START = 32'hFFCCFFCC;
  localparam logic [31:0] MARK_CHUNK_END   = 32'hFFDDFFDD;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HUNT = 2'd1,
    PH_SIZE = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } in_word_t;

  typedef struct packed {
    logic        store_valid;
    logic [16:0] store_addr;
    logic [7:0]  store_data;
    logic        overflow;
    logic        ack;
    logic        done_res;
    logic        timed_out;
    logic [23:0] frame_length;
    logic        busy_res;
  } out_word_t;

endpackage

`default_nettype wire

### sv/chunked_frame_deframer_top.sv
// Top level of the chunked frame deframer: phase machine, counters and
// config registers. Depends on cfd_pkg and cfd_out_buf.
`default_nettype none

// Usage
//   src channel: one word per event (start, received byte, 1 ms tick),
//   taken at a rising edge with src_valid high and src_stall low.
//   dst channel: exactly one result word per source word, in order, taken
//   at a rising edge with dst_valid high and dst_stall low.
//   cfg port: cfg_we with cfg_index 0 writes chunk_bytes, 1 writes
//   timeout_ticks; write only while the block is idle.
// Handling and throughput
//   A source word is handled in the cycle it is taken: the marker window
//   compare and counter updates sit between the state registers and the
//   result buffer, which registers the result. One word per cycle is
//   sustained unless dst stalls; the two-entry buffer sets the limit.
// Reset
//   rst (synchronous) returns the phase to idle, clears the window and
//   counters, loads chunk_bytes 512 and timeout_ticks 1000, empties buffer.
// Receiver stall
//   While dst is stalled one more result is held in the skid entry; once
//   it is occupied src_stall rises and holds until a result is taken.
module chunked_frame_deframer_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              src_valid,
  output logic                   src_stall,
  input  wire cfd_pkg::in_word_t src_word,
  output logic                   dst_valid,
  input  wire logic              dst_stall,
  output cfd_pkg::out_word_t     dst_word,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [15:0]       cfg_data
);
  import cfd_pkg::*;

  localparam logic [WI_BITS-1:0] BufLimit = WI_BITS'(BUFFER_BYTES);

  // configuration
  logic [15:0] chunk_bytes;
  logic [15:0] timeout_ticks;

  // reception state
  phase_t              phase, phase_next;
  logic [31:0]         window, window_next;
  logic [1:0]          len_cnt, len_cnt_next;
  logic [23:0]         ann_len, ann_len_next;
  logic [WI_BITS-1:0]  wr_idx, wr_idx_next;
  logic [IC_BITS-1:0]  chunk_idx, chunk_idx_next;
  logic [15:0]         idle_ticks, idle_ticks_next;

  logic                accept;
  logic                buf_full;
  out_word_t           res;

  // helpers for the data phase
  logic [WI_BITS-1:0]  wr_inc;
  logic [IC_BITS-1:0]  chunk_inc;
  logic [WI_BITS-1:0]  frame_end;
  logic [IC_BITS-1:0]  chunk_end;
  logic [15:0]         ticks_inc;

  assign src_stall = buf_full;
  assign accept    = src_valid && !buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_bytes   <= CHUNK_BYTES_RESET;
      timeout_ticks <= TIMEOUT_TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHUNK_BYTES:   chunk_bytes   <= cfg_data;
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      window     <= '0;
      len_cnt    <= '0;
      ann_len    <= '0;
      wr_idx     <= '0;
      chunk_idx  <= '0;
      idle_ticks <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      window     <= window_next;
      len_cnt    <= len_cnt_next;
      ann_len    <= ann_len_next;
      wr_idx     <= wr_idx_next;
      chunk_idx  <= chunk_idx_next;
      idle_ticks <= idle_ticks_next;
    end
  end

  assign wr_inc    = wr_idx + WI_BITS'(1);
  assign chunk_inc = chunk_idx + IC_BITS'(1);
  assign frame_end = WI_BITS'(ann_len) + WI_BITS'(4);
  assign chunk_end = IC_BITS'(chunk_bytes) + IC_BITS'(4);
  assign ticks_inc = (idle_ticks != 16'hFFFF) ? idle_ticks + 16'd1 : idle_ticks;

  always_comb begin
    phase_next      = phase;
    window_next     = window;
    len_cnt_next    = len_cnt;
    ann_len_next    = ann_len;
    wr_idx_next     = wr_idx;
    chunk_idx_next  = chunk_idx;
    idle_ticks_next = idle_ticks;
    res             = '0;

    if (src_word.kind == KIND_START) begin
      // restart from the hunt; the window is kept
      len_cnt_next    = '0;
      ann_len_next    = '0;
      wr_idx_next     = '0;
      chunk_idx_next  = '0;
      idle_ticks_next = '0;
      phase_next      = PH_HUNT;
    end else if (src_word.kind == KIND_BYTE && phase != PH_IDLE) begin
      idle_ticks_next = '0;
      window_next     = {window[23:0], src_word.data};
      case (phase)
        PH_HUNT: begin
          if (window_next == MARK_START) begin
            phase_next = PH_SIZE;
          end
        end
        PH_SIZE: begin
          // little-endian length, one byte at a time
          case (len_cnt)
            2'd0:    ann_len_next = ann_len | {16'd0, src_word.data};
            2'd1:    ann_len_next = ann_len | {8'd0, src_word.data, 8'd0};
            default: ann_len_next = ann_len | {src_word.data, 16'd0};
          endcase
          if (len_cnt == 2'd2) begin
            len_cnt_next = '0;
            wr_idx_next  = '0;
            phase_next   = PH_DATA;
          end else begin
            len_cnt_next = len_cnt + 2'd1;
          end
        end
        default: begin
          if (window_next == MARK_CHUNK_START) begin
            // rewind by the partial chunk, marker bytes included
            wr_idx_next    = wr_idx - WI_BITS'(chunk_idx);
            chunk_idx_next = '0;
          end else begin
            if (wr_idx < BufLimit) begin
              res.store_valid = 1'b1;
              res.store_addr  = wr_idx[IC_BITS-1:0];
              res.store_data  = src_word.data;
            end else begin
              res.overflow = 1'b1;
            end
            wr_idx_next    = wr_inc;
            chunk_idx_next = chunk_inc;
            if (window_next == MARK_CHUNK_END) begin
              // frame end wins over chunk end; strip the marker either way
              if (wr_inc == frame_end) begin
                wr_idx_next        = wr_inc - WI_BITS'(4);
                res.ack            = 1'b1;
                res.done_res       = 1'b1;
                res.frame_length   = ann_len;
                phase_next         = PH_IDLE;
              end else if (chunk_inc == chunk_end) begin
                wr_idx_next    = wr_inc - WI_BITS'(4);
                res.ack        = 1'b1;
                chunk_idx_next = '0;
              end
            end
          end
        end
      endcase
    end else if (src_word.kind == KIND_TICK && phase != PH_IDLE) begin
      idle_ticks_next = ticks_inc;
      if (ticks_inc > timeout_ticks) begin
        res.timed_out = 1'b1;
        phase_next    = PH_IDLE;
      end
    end

    res.busy_res = (phase_next != PH_IDLE);
  end

  cfd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_word (res),
    .full      (buf_full),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_word  (dst_word)
  );

`ifndef NO_ASSERTIONS
  // a full skid entry means a result is on show
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    src_stall |-> dst_valid)
    else $error("src_stall raised with no result on dst");

  // a finished frame leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (dst_valid && dst_word.done_res) |-> !dst_word.busy_res)
    else $error("done result reports busy");

  // a byte is either stored or dropped, never both
  a_store_xor_ovf: assert property (@(posedge clk) disable iff (rst)
    dst_valid |-> !(dst_word.store_valid && dst_word.overflow))
    else $error("store and overflow in one result");

  // an accepted start arms the receiver
  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    (accept && src_word.kind == KIND_START) |=> (phase == PH_HUNT))
    else $error("start did not enter the hunt phase");
`endif

endmodule

`default_nettype wire

### sv/cfd_out_buf.sv
// Two-entry result buffer (output register plus skid) for the deframer.
// Depends on cfd_pkg for the result word type.
`default_nettype none

module cfd_out_buf (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire cfd_pkg::out_word_t push_word,
  output logic                  full,
  output logic                  dst_valid,
  input  wire logic             dst_stall,
  output cfd_pkg::out_word_t    dst_word
);
  import cfd_pkg::*;

  out_word_t skid_word;
  logic      skid_full;
  logic      take;

  assign take = dst_valid && !dst_stall;
  assign full = skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (take) begin
        skid_full <= 1'b0;
      end
    end else if (push) begin
      if (!dst_valid || take) begin
        dst_valid <= 1'b1;
      end else begin
        skid_full <= 1'b1;
      end
    end else if (take) begin
      dst_valid <= 1'b0;
    end
  end

  // payload: refill from skid first, else from the new word
  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (take) begin
        dst_word <= skid_word;
      end
    end else if (push) begin
      if (!dst_valid || take) begin
        dst_word <= push_word;
      end else begin
        skid_word <= push_word;
      end
    end
  end

endmodule

`default_nettype wire

### verif/cfd_result_checker.sv
// Result checker for the chunked frame deframer: watches both word channels,
// predicts each result word and compares it field by field. Depends on cfd_pkg.
`default_nettype none

module cfd_result_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               src_valid,
  input  wire logic               src_stall,
  input  wire cfd_pkg::in_word_t  src_word,
  input  wire logic               dst_valid,
  input  wire logic               dst_stall,
  input  wire cfd_pkg::out_word_t dst_word,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data,
  output int                      pending,
  output int                      failures
);

  timeunit 1ns;
  timeprecision 1ps;

  import cfd_pkg::*;

  // Receiver state as the deframer should hold it
  phase_t      rx_phase;
  logic [31:0] window;
  logic [1:0]  len_bytes;
  logic [23:0] frame_len;
  logic [24:0] wr_index;
  logic [16:0] chunk_index;
  logic [15:0] idle_count;
  logic [15:0] chunk_len;
  logic [15:0] tick_limit;

  out_word_t expected_words[$];
  int        mismatches = 0;

  function automatic void clear_rx();
    len_bytes   = '0;
    frame_len   = '0;
    wr_index    = '0;
    chunk_index = '0;
    idle_count  = '0;
  endfunction

  // Advance the receiver by one source word and return the result word it causes
  function automatic out_word_t deframe_step(in_word_t w);
    out_word_t r;
    r = '0;
    if (w.kind == KIND_START) begin
      clear_rx();
      rx_phase = PH_HUNT;
    end else if (w.kind == KIND_BYTE && rx_phase != PH_IDLE) begin
      idle_count = '0;
      window = {window[23:0], w.data};
      case (rx_phase)
        PH_HUNT: begin
          if (window == MARK_START) rx_phase = PH_SIZE;
        end
        PH_SIZE: begin
          frame_len[8*len_bytes +: 8] = frame_len[8*len_bytes +: 8] | w.data;
          if (len_bytes == 2'd2) begin
            len_bytes = '0;
            wr_index  = '0;
            rx_phase  = PH_DATA;
          end else begin
            len_bytes = len_bytes + 2'd1;
          end
        end
        default: begin
          if (window == MARK_CHUNK_START) begin
            // rewind over the partial chunk, marker bytes included
            wr_index    = wr_index - chunk_index;
            chunk_index = '0;
          end else begin
            if (wr_index < BUFFER_BYTES) begin
              r.store_valid = 1'b1;
              r.store_addr  = wr_index[16:0];
              r.store_data  = w.data;
            end else begin
              r.overflow = 1'b1;
            end
            wr_index    = wr_index + 25'd1;
            chunk_index = chunk_index + 17'd1;
            if (window == MARK_CHUNK_END) begin
              if (wr_index == frame_len + 25'd4) begin
                wr_index       = wr_index - 25'd4;
                r.ack          = 1'b1;
                r.done_res     = 1'b1;
                r.frame_length = frame_len;
                rx_phase       = PH_IDLE;
              end else if (chunk_index == chunk_len + 17'd4) begin
                wr_index    = wr_index - 25'd4;
                r.ack       = 1'b1;
                chunk_index = '0;
              end
            end
          end
        end
      endcase
    end else if (w.kind == KIND_TICK && rx_phase != PH_IDLE) begin
      if (idle_count != 16'hFFFF) idle_count = idle_count + 16'd1;
      if (idle_count > tick_limit) begin
        r.timed_out = 1'b1;
        rx_phase    = PH_IDLE;
      end
    end
    r.busy_res = (rx_phase != PH_IDLE);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      rx_phase   = PH_IDLE;
      window     = '0;
      clear_rx();
      chunk_len  = CHUNK_BYTES_RESET;
      tick_limit = TIMEOUT_TICKS_RESET;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_CHUNK_BYTES) chunk_len = cfg_data;
        else if (cfg_index == REG_TIMEOUT_TICKS) tick_limit = cfg_data;
      end
      // results lag their source word, so retire before predicting
      if (dst_valid && !dst_stall) begin
        if (expected_words.size() == 0) begin
          $error("result word 0x%0h with nothing expected", dst_word);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          check_field("store_valid", want.store_valid, dst_word.store_valid);
          check_field("store_addr", want.store_addr, dst_word.store_addr);
          check_field("store_data", want.store_data, dst_word.store_data);
          check_field("overflow", want.overflow, dst_word.overflow);
          check_field("ack", want.ack, dst_word.ack);
          check_field("done_res", want.done_res, dst_word.done_res);
          check_field("timed_out", want.timed_out, dst_word.timed_out);
          check_field("frame_length", want.frame_length, dst_word.frame_length);
          check_field("busy_res", want.busy_res, dst_word.busy_res);
        end
      end
      if (src_valid && !src_stall) expected_words.push_back(deframe_step(src_word));
    end
    pending  = expected_words.size();
    failures = mismatches + pending;
  end

endmodule

`default_nettype wire

### verif/tb_chunked_frame_deframer_top.sv
// Testbench top for the chunked frame deframer: clock, reset, word stimulus
// and verdict. Depends on cfd_pkg, chunked_frame_deframer_top, cfd_result_checker.
`default_nettype none

module tb_chunked_frame_deframer_top;

  timeunit 1ns;
  timeprecision 1ps;

  import cfd_pkg::*;

  // Kind code that the block must ignore
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam int RANDOM_ITEMS = 1400;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 2000000;

  logic        clk;
  logic        rst = 1'b1;
  logic        src_valid = 1'b0;
  logic        src_stall;
  in_word_t    src_word = '0;
  logic        dst_valid;
  logic        dst_stall = 1'b0;
  out_word_t   dst_word;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_CHUNK_BYTES;
  logic [15:0] cfg_data = '0;

  int pending;
  int failures;

  // Sender bookkeeping
  int   words_sent = 0;
  int   burst_left = 0;
  logic quiet = 1'b0;   // hold both sides busy-free during the long runs
  int   cur_chunk;
  int   cur_limit;

  int cycles = 0;
  int stall_count = 0;

  chunked_frame_deframer_top uut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_word  (src_word),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_word  (dst_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cfd_result_checker result_check (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_word  (src_word),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_word  (dst_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .failures  (failures)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver stall pattern: cycle through free flow, coin-toss stalls,
  // long holds and a regular one-in-three stall, in turn.
  always @(posedge clk) begin
    stall_count <= stall_count + 1;
    if (rst || quiet) begin
      dst_stall <= 1'b0;
    end else begin
      case ((stall_count / 256) % 4)
        0: dst_stall <= 1'b0;
        1: dst_stall <= ($urandom_range(0, 1) == 0);
        2: dst_stall <= ((stall_count % 16) < 11);
        default: dst_stall <= ((stall_count % 3) == 0);
      endcase
    end
  end

  function automatic logic [7:0] rand_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    // lean on 0xFF so partial markers turn up in the window
    if ($urandom_range(0, 7) == 0) b = 8'hFF;
    return b;
  endfunction

  // Offer one word and hold it until the block takes it. Bursts of random
  // length are separated by random gaps; stall is judged at the falling edge,
  // where nothing driven at the rising edge is still settling.
  task automatic push_word(input logic [1:0] kind, input logic [7:0] data);
    in_word_t w;
    w.kind = kind;
    w.data = data;
    if (!quiet && burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      if ($urandom_range(0, 3) != 0) begin
        src_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    src_valid <= 1'b1;
    src_word  <= w;
    do @(negedge clk); while (src_stall);
    @(posedge clk);
    words_sent++;
  endtask

  task automatic push_marker(input logic [31:0] m);
    for (int i = 3; i >= 0; i--) push_word(KIND_BYTE, m[8*i +: 8]);
  endtask

  // A data byte, now and then preceded by a tick that stays under the timeout
  task automatic push_payload_byte();
    if (cur_limit != 0 && $urandom_range(0, 9) == 0) push_word(KIND_TICK, rand_byte());
    push_word(KIND_BYTE, rand_byte());
  endtask

  // Drop valid and hold until every expected result word has come back
  task automatic drain();
    src_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both registers; only called after reset or after a drain
  task automatic set_regs(input logic [15:0] chunk, input logic [15:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CHUNK_BYTES;
    cfg_data  <= chunk;
    @(posedge clk);
    cfg_index <= REG_TIMEOUT_TICKS;
    cfg_data  <= limit;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_chunk = chunk;
    cur_limit = limit;
  endtask

  // One frame: start, hunt noise, start marker, length, then chunks with
  // optional chunk-start markers and resends. Some frames are broken on
  // purpose: truncated, a corrupt marker ahead of the real one, a timeout,
  // or a pause until the block has caught up.
  task automatic send_frame();
    int style;
    int len;
    int remaining;
    int n;
    style = $urandom_range(0, 15);
    if (style == 0) len = $urandom_range(0, 24'hFFFFFF);
    else len = $urandom_range(0, (cur_chunk <= 12) ? 4 * cur_chunk + 3 : 40);

    push_word(KIND_START, rand_byte());
    repeat ($urandom_range(0, 3))
      push_word(($urandom_range(0, 5) == 0) ? KIND_NONE : KIND_BYTE, rand_byte());
    if (style == 1) push_marker({MARK_START[31:8], 8'h55});
    push_marker(MARK_START);
    push_word(KIND_BYTE, len[7:0]);
    push_word(KIND_BYTE, len[15:8]);
    push_word(KIND_BYTE, len[23:16]);

    if (style == 0) begin
      // cut off mid-chunk; the next start restarts reception
      repeat ($urandom_range(0, 12)) push_payload_byte();
      return;
    end
    if (style == 2 && cur_limit <= 20) begin
      // run the idle count past the limit, then one more tick while idle
      repeat (cur_limit + 2) push_word(KIND_TICK, rand_byte());
      return;
    end
    if (style == 3) drain();

    remaining = len;
    do begin
      n = (remaining < cur_chunk) ? remaining : cur_chunk;
      if ($urandom_range(0, 3) == 0) push_marker(MARK_CHUNK_START);
      if (n > 0 && $urandom_range(0, 7) == 0) begin
        // partial send, then rewind and resend the whole chunk
        repeat ($urandom_range(1, n)) push_payload_byte();
        push_marker(MARK_CHUNK_START);
      end
      repeat (n) push_payload_byte();
      push_marker(MARK_CHUNK_END);
      remaining -= n;
    end while (remaining > 0);
  endtask

  initial begin
    int frames;
    int random_start;
    logic [15:0] chunk_pick;
    logic [15:0] limit_pick;
    logic [23:0] big_len;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: two-byte chunks, timeout after three idle ticks
    set_regs(16'd2, 16'd3);
    push_word(KIND_BYTE, 8'hFF);        // idle: ignored, window untouched
    push_word(KIND_TICK, 8'h00);
    push_word(KIND_NONE, 8'hA5);
    push_word(KIND_START, 8'h00);
    push_word(KIND_START, 8'hFF);       // restart while already hunting
    push_marker(MARK_START);
    push_word(KIND_BYTE, 8'h03);        // length 3, little-endian
    push_word(KIND_BYTE, 8'h00);
    push_word(KIND_BYTE, 8'h00);
    push_marker(MARK_CHUNK_START);      // rewinds over its own stored bytes
    push_word(KIND_BYTE, 8'h00);
    push_word(KIND_BYTE, 8'hFF);
    push_marker(MARK_CHUNK_END);        // full chunk: strip and ack
    push_word(KIND_BYTE, 8'h80);
    push_marker(MARK_CHUNK_END);        // length reached: done
    push_word(KIND_START, 8'h5A);
    repeat (4) push_word(KIND_TICK, 8'h00);

    // Random frames, with a new register setting every few frames
    frames = 0;
    random_start = words_sent;
    while (words_sent - random_start < RANDOM_ITEMS) begin
      if (frames % 6 == 5) begin
        drain();
        case ($urandom_range(0, 5))
          0: chunk_pick = 16'd1;
          1: chunk_pick = 16'd2;
          2: chunk_pick = 16'hFFFF;
          default: chunk_pick = 16'($urandom_range(3, 12));
        endcase
        case ($urandom_range(0, 4))
          0: limit_pick = 16'd0;
          1: limit_pick = 16'hFFFF;
          2: limit_pick = 16'd1;
          default: limit_pick = 16'($urandom_range(2, 10));
        endcase
        set_regs(chunk_pick, limit_pick);
      end
      send_frame();
      frames++;
    end

    // Largest chunk size and largest timeout: idle ticks never abort, and
    // the frame ends on its length long before a chunk is full
    drain();
    set_regs(16'hFFFF, 16'hFFFF);
    quiet = 1'b1;
    big_len = 24'd40;
    push_word(KIND_START, 8'h00);
    repeat (30) push_word(KIND_TICK, 8'h00);
    push_marker(MARK_START);
    push_word(KIND_BYTE, big_len[7:0]);
    push_word(KIND_BYTE, big_len[15:8]);
    push_word(KIND_BYTE, big_len[23:16]);
    repeat (40) push_word(KIND_BYTE, rand_byte());
    push_marker(MARK_CHUNK_END);
    quiet = 1'b0;

    // Smallest chunk with a zero timeout
    drain();
    set_regs(16'd1, 16'd0);
    repeat (6) send_frame();

    drain();
    if (failures == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

### chunked_frame_deframer_top.f
sv/cfd_pkg.sv
sv/cfd_out_buf.sv
sv/chunked_frame_deframer_top.sv
verif/cfd_result_checker.sv
verif/tb_chunked_frame_deframer_top.sv
